FILE: rtl/cc2p_pkg.sv
// ----------------------------------------------------------------------------
// cc2p_pkg
// Constants shared by the CORDIC Cartesian-to-polar pipeline: the angle
// format, the arctangent table, the quarter-turn start angle and the gain.
// ----------------------------------------------------------------------------
package cc2p_pkg;

    // Angle word is signed Q3.29 regardless of the x/y datapath width.
    localparam int ANGLE_W   = 32;
    localparam int ATAN_SIZE = 16;

    typedef logic signed [ANGLE_W-1:0] t_angle;

    localparam t_angle HALF_PI_Q29 = 32'sd843314856;

    // Gain correction 0.607253 in Q0.30.
    localparam logic [29:0] GAIN_Q30 = 30'd652032944;

    // round(atan(2^-i) * 2^29)
    localparam t_angle ATAN_Q29 [ATAN_SIZE] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
        32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
        32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
        32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384
    };

endpackage

FILE: rtl/cc2p_iter.sv
// ----------------------------------------------------------------------------
// cc2p_iter
// One registered vectoring step: shift-and-add on x and y toward y = 0 and
// the matching arctangent added to or taken from the angle.
// ----------------------------------------------------------------------------
module cc2p_iter #(
    parameter int DATA_WIDTH = 32,
    parameter int SHIFT      = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [DATA_WIDTH-1:0]  i_x,
    input  logic signed [DATA_WIDTH-1:0]  i_y,
    input  cc2p_pkg::t_angle              i_angle,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [DATA_WIDTH-1:0]  o_x,
    output logic signed [DATA_WIDTH-1:0]  o_y,
    output cc2p_pkg::t_angle              o_angle
);
    import cc2p_pkg::*;

    logic                         r_valid;
    logic signed [DATA_WIDTH-1:0] r_x;
    logic signed [DATA_WIDTH-1:0] r_y;
    t_angle                       r_angle;
    logic signed [DATA_WIDTH-1:0] n_x;
    logic signed [DATA_WIDTH-1:0] n_y;
    t_angle                       n_angle;
    logic signed [DATA_WIDTH-1:0] w_sx;
    logic signed [DATA_WIDTH-1:0] w_sy;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_sx = i_x >>> SHIFT;
        w_sy = i_y >>> SHIFT;
        // A zero y counts as non-negative.
        if (!i_y[DATA_WIDTH-1]) begin
            n_x     = i_x + w_sy;
            n_y     = i_y - w_sx;
            n_angle = i_angle + ATAN_Q29[SHIFT];
        end else begin
            n_x     = i_x - w_sy;
            n_y     = i_y + w_sx;
            n_angle = i_angle - ATAN_Q29[SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_angle = r_angle;

endmodule

FILE: rtl/cordic_cartesian_to_polar.sv
// ----------------------------------------------------------------------------
// cordic_cartesian_to_polar
// Pipelined CORDIC vectoring: a point (x, y) in Q2.30 becomes its
// gain-corrected magnitude (Q2.30) and its angle in radians (Q3.29).
//
//   Channel | Valid       | Ready       | Payload
//   --------+-------------+-------------+------------------------------
//   input   | i_in_valid  | o_in_ready  | i_coord_x, i_coord_y
//   output  | o_out_valid | i_out_ready | o_magnitude, o_angle
//
// One item per cycle sustained while the output is not stalled. The stages,
// in order: the quarter-turn register, one register per vectoring step, the
// gain multiply register and the rounding/output register.
// Each stage holds its own valid bit and takes a new item when it is empty
// or its successor takes its item, so a stall fills bubbles before it pushes
// back on the input. Synchronous reset clears only the valid bits.
// ----------------------------------------------------------------------------
module cordic_cartesian_to_polar #(
    parameter int ITERATIONS = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [31:0]       i_coord_x,
    input  logic signed [31:0]       i_coord_y,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [31:0]       o_magnitude,
    output cc2p_pkg::t_angle         o_angle
);
    import cc2p_pkg::*;

    localparam int DROP  = 32 - DATA_WIDTH;
    localparam int PROD_W = DATA_WIDTH + 32;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< 29;

    // Stage chain: index 0 is the quarter-turn register, k is step k.
    logic                         w_valid [0:ITERATIONS];
    logic                         w_ready [0:ITERATIONS];
    logic signed [DATA_WIDTH-1:0] w_x     [0:ITERATIONS];
    logic signed [DATA_WIDTH-1:0] w_y     [0:ITERATIONS];
    t_angle                       w_angle [0:ITERATIONS];

    // Quarter-turn stage.
    logic                         r_s0_valid;
    logic signed [DATA_WIDTH-1:0] r_s0_x;
    logic signed [DATA_WIDTH-1:0] r_s0_y;
    t_angle                       r_s0_angle;
    logic signed [DATA_WIDTH-1:0] w_xin;
    logic signed [DATA_WIDTH-1:0] w_yin;
    logic signed [DATA_WIDTH-1:0] n_s0_x;
    logic signed [DATA_WIDTH-1:0] n_s0_y;
    t_angle                       n_s0_angle;

    // Gain and output stages.
    logic                         r_p_valid;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [PROD_W-1:0]     n_prod;
    logic signed [30:0]           w_gain;
    logic                         w_p_ready;
    logic                         r_o_valid;
    logic signed [DATA_WIDTH-1:0] r_mag;
    t_angle                       r_p_angle;
    t_angle                       r_o_angle;
    logic signed [PROD_W-1:0]     n_sum;
    logic                         w_o_ready;

    assign w_xin = i_coord_x[31:DROP];
    assign w_yin = i_coord_y[31:DROP];

    always_comb begin
        if (!w_yin[DATA_WIDTH-1]) begin
            n_s0_x     = w_yin;
            n_s0_y     = -w_xin;
            n_s0_angle = HALF_PI_Q29;
        end else begin
            n_s0_x     = -w_yin;
            n_s0_y     = w_xin;
            n_s0_angle = -HALF_PI_Q29;
        end
    end

    assign o_in_ready = !r_s0_valid || w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s0_x     <= n_s0_x;
            r_s0_y     <= n_s0_y;
            r_s0_angle <= n_s0_angle;
        end
    end

    assign w_valid[0] = r_s0_valid;
    assign w_x[0]     = r_s0_x;
    assign w_y[0]     = r_s0_y;
    assign w_angle[0] = r_s0_angle;

    for (genvar k = 1; k <= ITERATIONS; k++) begin : g_step
        cc2p_iter #(
            .DATA_WIDTH (DATA_WIDTH),
            .SHIFT      (k - 1)
        ) u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k-1]),
            .o_ready (w_ready[k-1]),
            .i_x     (w_x[k-1]),
            .i_y     (w_y[k-1]),
            .i_angle (w_angle[k-1]),
            .o_valid (w_valid[k]),
            .i_ready (w_ready[k]),
            .o_x     (w_x[k]),
            .o_y     (w_y[k]),
            .o_angle (w_angle[k])
        );
    end

    // Gain multiply: x times K, both signed, full product kept.
    assign w_gain    = signed'({1'b0, GAIN_Q30});
    assign n_prod    = w_x[ITERATIONS] * w_gain;
    assign w_p_ready = !r_p_valid || w_o_ready;
    assign w_ready[ITERATIONS] = w_p_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_p_ready) begin
            r_p_valid <= w_valid[ITERATIONS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_ready && w_valid[ITERATIONS]) begin
            r_prod    <= n_prod;
            r_p_angle <= w_angle[ITERATIONS];
        end
    end

    // Round half up, drop 30 fraction bits, wrap to the datapath width.
    assign n_sum     = r_prod + ROUND_HALF;
    assign w_o_ready = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_ready) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_ready && r_p_valid) begin
            r_mag     <= n_sum[DATA_WIDTH+29:30];
            r_o_angle <= r_p_angle;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_magnitude = 32'(r_mag) <<< DROP;
    assign o_angle     = r_o_angle;

endmodule

FILE: rtl/cc2p_checker.sv
// ----------------------------------------------------------------------------
// cc2p_checker
// Port-level checks for the CORDIC Cartesian-to-polar pipeline, bound to
// the top level.
// ----------------------------------------------------------------------------
module cc2p_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic signed [31:0]   i_coord_x,
    input logic signed [31:0]   i_coord_y,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic signed [31:0]   o_magnitude,
    input cc2p_pkg::t_angle     o_angle
);
    import cc2p_pkg::*;

    // Quarter-turn start angle plus every arctangent entry; the origin reaches it.
    localparam t_angle ANGLE_MAX = 32'sd1779218349;

    // Reset empties the pipeline, so no item shows on the next cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // With the output free, every stage can move, so the input must be open.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output is free");

    // The accumulated angle never leaves its reachable range.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_angle <= ANGLE_MAX) && (o_angle >= -ANGLE_MAX))
        else $error("angle out of range");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_magnitude) && $stable(o_angle))
        else $error("stalled result changed");

    // A waiting input item holds until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_coord_x) && $stable(i_coord_y))
        else $error("waiting input item changed");

endmodule

bind cordic_cartesian_to_polar cc2p_checker u_cc2p_checker (.*);
